// File: design/ght_pkg.sv
// ----------------------------------------------------------------------------
// ght_pkg
// shared types, codes and helpers of the generational handle table
// ----------------------------------------------------------------------------
`default_nettype none

package ght_pkg;

   localparam int SLOTS        = 64;
   localparam int SERIAL_BITS  = 16;
   localparam int PAYLOAD_BITS = 32;

   localparam int SLOT_W  = $clog2(SLOTS);
   localparam int COUNT_W = $clog2(SLOTS + 1);

   // fixed widths of the channel fields
   localparam int TYPE_FIELD_W    = 3;
   localparam int INDEX_FIELD_W   = 6;
   localparam int SERIAL_FIELD_W  = 16;
   localparam int PAYLOAD_FIELD_W = 32;
   localparam int COUNT_FIELD_W   = 7;

   typedef enum logic [TYPE_FIELD_W-1:0] {
      OP_ADD      = 3'd0,
      OP_REMOVE   = 3'd1,
      OP_LOOKUP_H = 3'd2,
      OP_LOOKUP_I = 3'd3,
      OP_NEXT     = 3'd4,
      OP_CLEAR    = 3'd5
   } ght_op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_RANGE     = 2'd3
   } ght_status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SCAN
   } ght_state_type;

   typedef struct packed {
      logic [TYPE_FIELD_W-1:0]    req_type;
      logic [INDEX_FIELD_W-1:0]   slot_index;
      logic [SERIAL_FIELD_W-1:0]  handle_serial;
      logic                       from_start;
      logic [PAYLOAD_FIELD_W-1:0] payload;
   } ght_req_item_type;

   typedef struct packed {
      ght_status_type             status;
      logic [INDEX_FIELD_W-1:0]   out_index;
      logic [SERIAL_FIELD_W-1:0]  out_serial;
      logic [PAYLOAD_FIELD_W-1:0] out_payload;
      logic [COUNT_FIELD_W-1:0]   live_count;
   } ght_rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic capture;      // latch request, first memory read
      logic finish;       // execute request, load result
      logic fetch_next;   // read the slot found by the scan
      logic finish_scan;  // load result of a successful next
   } ght_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic next_hit;
      logic out_free;
   } ght_stat_type;

   // lowest set bit: {found, index}
   function automatic logic [SLOT_W:0] lowest_set(input logic [SLOTS-1:0] vec);
      logic [SLOT_W:0] res;
      res = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (vec[i]) begin
            res = {1'b1, SLOT_W'(i)};
         end
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: design/ght_if.sv
// ----------------------------------------------------------------------------
// ght_if
// valid/ready channels carrying request and response items
// ----------------------------------------------------------------------------
`default_nettype none

interface ght_req_if import ght_pkg::*; ();
   logic             valid;
   logic             ready;
   ght_req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ght_rsp_if import ght_pkg::*; ();
   logic             valid;
   logic             ready;
   ght_rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/ght_controller.sv
// ----------------------------------------------------------------------------
// ght_controller
// sequences capture, execute and the extra read of a next request
// ----------------------------------------------------------------------------
`default_nettype none

module ght_controller import ght_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   output logic        req_ready,
   input  ght_stat_type stat,
   output ght_cmd_type  cmd
);

   ght_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = FSM_EXEC;
            end
         end
         FSM_EXEC: begin
            if (stat.next_hit) begin
               cmd.fetch_next = 1'b1;
               state_in       = FSM_SCAN;
            end else if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = FSM_IDLE;
            end
         end
         FSM_SCAN: begin
            if (stat.out_free) begin
               cmd.finish_scan = 1'b1;
               state_in        = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: design/ght_datapath.sv
// ----------------------------------------------------------------------------
// ght_datapath
// occupancy flags, serial and payload memories, scans and result register
// ----------------------------------------------------------------------------
`default_nettype none

module ght_datapath import ght_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  ght_cmd_type      cmd,
   output ght_stat_type     stat,
   input  ght_req_item_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output ght_rsp_item_type rsp_data
);

   // memories
   logic [SERIAL_BITS-1:0]  ser_mem [SLOTS];
   logic [PAYLOAD_BITS-1:0] pay_mem [SLOTS];

   // table state
   logic [SLOTS-1:0]   occ_ff;
   logic [SLOTS-1:0]   ser_vld_ff;   // serial entry written since reset or clear
   logic [COUNT_W-1:0] count_ff;

   // latched request
   logic [TYPE_FIELD_W-1:0]  op_ff;
   logic [INDEX_FIELD_W-1:0] idx_ff;
   logic [SERIAL_BITS-1:0]   hser_ff;
   logic                     start_ff;
   logic [PAYLOAD_BITS-1:0]  pay_ff;
   logic [SLOT_W-1:0]        addr_ff;
   logic                     free_any_ff;

   // read data
   logic [SERIAL_BITS-1:0]  rd_ser_ff;
   logic                    rd_vld_ff;
   logic [PAYLOAD_BITS-1:0] rd_pay_ff;

   // result register
   logic             rsp_valid_ff;
   ght_rsp_item_type rsp_data_ff;

   logic [SLOT_W:0]        free_enc;
   logic [SLOT_W:0]        scan_enc;
   logic [SLOT_W-1:0]      rd_addr;
   logic                   rd_en;
   logic [SERIAL_BITS-1:0] ser_cur;
   logic                   in_range;
   logic                   occ_cur;
   logic                   match;
   logic                   first_ok;
   logic [SLOTS-1:0]       gt_mask;
   logic [SLOTS-1:0]       scan_vec;

   ght_status_type          res_status;
   logic                    res_show;
   logic [SERIAL_BITS-1:0]  res_ser;
   logic [PAYLOAD_BITS-1:0] res_pay;
   logic [COUNT_W-1:0]      count_in;
   logic                    occ_set;
   logic                    occ_clr;
   logic                    wr_en;
   logic                    clear_all;
   logic                    load_rsp;

   assign free_enc = lowest_set(~occ_ff);

   assign rd_en   = cmd.capture | cmd.fetch_next;
   assign rd_addr = cmd.fetch_next ? scan_enc[SLOT_W-1:0] :
                    (req_data.req_type == OP_ADD) ? free_enc[SLOT_W-1:0] :
                    SLOT_W'(req_data.slot_index);

   assign ser_cur  = rd_vld_ff ? rd_ser_ff : '0;
   assign in_range = (32'(idx_ff) < 32'(SLOTS));
   assign occ_cur  = occ_ff[addr_ff];
   assign match    = (ser_cur == hser_ff);
   assign first_ok = !start_ff && in_range && occ_cur && match;
   assign gt_mask  = ({SLOTS{1'b1}} << addr_ff) << 1;
   assign scan_vec = occ_ff & (first_ok ? gt_mask : {SLOTS{1'b1}});
   assign scan_enc = lowest_set(scan_vec);

   assign stat.next_hit = (op_ff == OP_NEXT) && scan_enc[SLOT_W];
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign load_rsp = cmd.finish | cmd.finish_scan;

   always_comb begin
      res_status = ST_NOT_FOUND;
      res_show   = 1'b0;
      res_ser    = ser_cur;
      res_pay    = rd_pay_ff;
      count_in   = count_ff;
      occ_set    = 1'b0;
      occ_clr    = 1'b0;
      wr_en      = 1'b0;
      clear_all  = 1'b0;
      if (cmd.finish_scan) begin
         res_status = ST_OK;
         res_show   = 1'b1;
      end else if (cmd.finish) begin
         case (op_ff)
            OP_ADD: begin
               if (free_any_ff) begin
                  res_status = ST_OK;
                  res_show   = 1'b1;
                  res_ser    = ser_cur + SERIAL_BITS'(1);
                  res_pay    = pay_ff;
                  count_in   = count_ff + COUNT_W'(1);
                  occ_set    = 1'b1;
                  wr_en      = 1'b1;
               end else begin
                  res_status = ST_FULL;
               end
            end
            OP_REMOVE: begin
               if (!in_range) begin
                  res_status = ST_RANGE;
               end else if (occ_cur) begin
                  res_status = ST_OK;
                  res_show   = 1'b1;
                  count_in   = count_ff - COUNT_W'(1);
                  occ_clr    = 1'b1;
               end
            end
            OP_LOOKUP_H: begin
               if (!in_range) begin
                  res_status = ST_RANGE;
               end else if (occ_cur && match) begin
                  res_status = ST_OK;
                  res_show   = 1'b1;
               end
            end
            OP_LOOKUP_I: begin
               if (!in_range) begin
                  res_status = ST_RANGE;
               end else if (occ_cur) begin
                  res_status = ST_OK;
                  res_show   = 1'b1;
               end
            end
            OP_CLEAR: begin
               res_status = ST_OK;
               count_in   = '0;
               clear_all  = 1'b1;
            end
            default: begin
               // next with nothing found and unused codes
               res_status = ST_NOT_FOUND;
            end
         endcase
      end
   end

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff       <= req_data.req_type;
         idx_ff      <= req_data.slot_index;
         hser_ff     <= SERIAL_BITS'(req_data.handle_serial);
         start_ff    <= req_data.from_start;
         pay_ff      <= PAYLOAD_BITS'(req_data.payload);
         free_any_ff <= free_enc[SLOT_W];
      end
      if (rd_en) begin
         addr_ff   <= rd_addr;
         rd_vld_ff <= ser_vld_ff[rd_addr];
      end
   end

   // serial memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ser_mem[addr_ff] <= res_ser;
      end
      if (rd_en) begin
         rd_ser_ff <= ser_mem[rd_addr];
      end
   end

   // payload memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pay_mem[addr_ff] <= pay_ff;
      end
      if (rd_en) begin
         rd_pay_ff <= pay_mem[rd_addr];
      end
   end

   // table flags and count
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= '0;
         ser_vld_ff <= '0;
         count_ff   <= '0;
      end else if (load_rsp) begin
         count_ff <= count_in;
         if (clear_all) begin
            occ_ff     <= '0;
            ser_vld_ff <= '0;
         end else begin
            if (occ_set) begin
               occ_ff[addr_ff] <= 1'b1;
            end
            if (occ_clr) begin
               occ_ff[addr_ff] <= 1'b0;
            end
            if (wr_en) begin
               ser_vld_ff[addr_ff] <= 1'b1;
            end
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff.status      <= res_status;
         rsp_data_ff.out_index   <= res_show ? INDEX_FIELD_W'(addr_ff) : '0;
         rsp_data_ff.out_serial  <= res_show ? SERIAL_FIELD_W'(res_ser) : '0;
         rsp_data_ff.out_payload <= res_show ? PAYLOAD_FIELD_W'(res_pay) : '0;
         rsp_data_ff.live_count  <= COUNT_FIELD_W'(count_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: design/generational_handle_table.sv
// ----------------------------------------------------------------------------
// generational_handle_table
// slot table handing out (index, serial) handles for stored identifiers
// ----------------------------------------------------------------------------
// Each request item gives one response item. Add takes the lowest free slot,
// bumps its wrapping serial and returns the handle; remove frees a slot by
// index; lookups by handle (serial must match) or by index return the stored
// identifier; next returns the first occupied slot after a valid handle, or
// from slot 0; clear-all empties the table and zeroes every serial. On accept,
// the serial and payload memories are read at the slot chosen by the
// free-slot priority encoder or by the request index; the execute step then
// decides, writes back and loads the response register once the output
// register is free. A next request that finds a slot passes through an extra
// scan state, since the found slot needs a second read of the memories. The
// block is ready only between requests; a finished response waiting in the
// output register does not hold up the next accept, only the execute step of
// the next item. No clearing pass is needed after reset: serials carry one
// flag per slot, so reset and clear-all take effect at once.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_table import ght_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   ght_req_if.sink   req_chan,
   ght_rsp_if.source rsp_chan
);

   // command and status between the two halves
   ght_cmd_type  cmd;
   ght_stat_type stat;
   logic         ctrl_ready;

   ght_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table storage, scans and the response register
   ght_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_data  (req_chan.data),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_data  (rsp_chan.data)
   );

   assign req_chan.ready = ctrl_ready;

endmodule

`default_nettype wire

// File: design/ght_checker.sv
// ----------------------------------------------------------------------------
// ght_checker
// port-level checks of the handle table, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module ght_checker import ght_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire ght_rsp_item_type rsp_data
);

   // one item at a time: no accept in the cycle after an accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   // failed requests show no slot details
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
      (rsp_data.out_index == '0 && rsp_data.out_serial == '0 &&
       rsp_data.out_payload == '0))
      else $error("slot details on a failed response");

   // full only when every slot is live
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_FULL) |->
      (rsp_data.live_count == COUNT_FIELD_W'(SLOTS)))
      else $error("table full with free slots");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

endmodule

bind generational_handle_table ght_checker u_ght_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_data  (rsp_chan.data)
);

`default_nettype wire
